// ===== hw/rtl/rmt_pkg.sv =====
// ============================================================================
// rmt_pkg: shared types and constants of the running median tracker
// Holds the fixed field widths, the link that joins neighbouring cells and
// the control states of the top level.
// ============================================================================
`default_nettype none

package rmt_pkg;

    // Field widths fixed by the interface.
    localparam int SAMPLE_W    = 32;
    localparam int MEDIAN_W    = 33;
    localparam int COUNT_OUT_W = 9;

    // Each cell contributes the low-middle and high-middle values side by side.
    localparam int PICK_W      = 2 * SAMPLE_W;

    // What one cell hands to the next one along the sorted chain.
    typedef struct packed {
        logic [SAMPLE_W-1:0] value;  // stored value of the cell
        logic                gt;     // cell is occupied and holds more than the sample
        logic                occ;    // cell holds a stored sample
    } link_t;

    // Control states of the top level.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_GATHER,
        ST_OUT
    } state_t;

endpackage : rmt_pkg

`default_nettype wire

// ===== hw/rtl/rmt_cell.sv =====
// ============================================================================
// rmt_cell: one slot of the sorted insertion chain
// Holds one stored sample. On an insert it keeps its value, takes the new
// sample, or takes its lower neighbour's value, so that the chain stays in
// ascending order. It also offers its value to the median gather tree.
// ============================================================================
`default_nettype none

module rmt_cell #(
    parameter int INDEX = 0,
    parameter int IDX_W = 8,
    parameter int CNT_W = 9
) (
    input  wire logic                          aclk,
    input  wire logic                          ins_en,
    input  wire logic [rmt_pkg::SAMPLE_W-1:0]  sample,
    input  wire logic [CNT_W-1:0]              count,
    input  wire logic [IDX_W-1:0]              lo_idx,
    input  wire logic [IDX_W-1:0]              hi_idx,
    input  wire rmt_pkg::link_t                link_in,
    output rmt_pkg::link_t                     link_out,
    output logic [rmt_pkg::PICK_W-1:0]         pick
);

    import rmt_pkg::*;

    localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(INDEX);
    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic [SAMPLE_W-1:0] value_reg;
    logic [SAMPLE_W-1:0] value_next;
    logic                occ;
    logic                gt;
    logic                take_sample;

    // Occupancy follows from the fill count; greater-than is strict so that
    // an equal sample lands after the values already stored.
    assign occ = (MY_CNT < count);
    assign gt  = occ && ($signed(value_reg) > $signed(sample));

    // The first cell that is greater, or the first empty one, takes the sample.
    assign take_sample = !link_in.gt && (gt || (!occ && link_in.occ));

    always_comb begin
        value_next = value_reg;
        if (ins_en) begin
            if (link_in.gt) begin
                value_next = link_in.value;
            end else if (take_sample) begin
                value_next = sample;
            end
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

    assign link_out.value = value_reg;
    assign link_out.gt    = gt;
    assign link_out.occ   = occ;

    // Offer the value in the lane of each middle position this cell holds.
    assign pick = {((lo_idx == MY_IDX) ? value_reg : '0),
                   ((hi_idx == MY_IDX) ? value_reg : '0)};

endmodule : rmt_cell

`default_nettype wire

// ===== hw/rtl/rmt_or_tree.sv =====
// ============================================================================
// rmt_or_tree: registered four-way OR reduction
// Collects the single non-zero contribution of a row of cells. Every
// internal node is a register, so each level of the tree adds one register
// between the leaves and the root.
// ============================================================================
`default_nettype none

module rmt_or_tree #(
    parameter int N      = 256,
    parameter int W      = 64,
    parameter int LEVELS = 4
) (
    input  wire logic         aclk,
    input  wire logic [W-1:0] leaf_in [N],
    output logic      [W-1:0] root
);

    localparam int P        = 1 << (2 * LEVELS);
    localparam int INTERNAL = (P - 1) / 3;

    logic [W-1:0] leaf [P];
    logic [W-1:0] node [INTERNAL];

    // Leaves beyond the row are tied to zero.
    for (genvar j = 0; j < P; j++) begin : g_leaf
        if (j < N) begin : g_used
            assign leaf[j] = leaf_in[j];
        end else begin : g_pad
            assign leaf[j] = '0;
        end
    end

    // Heap layout: the children of node k are 4k+1 to 4k+4.
    for (genvar k = 0; k < INTERNAL; k++) begin : g_node
        logic [W-1:0] kid [4];
        for (genvar c = 0; c < 4; c++) begin : g_kid
            if (4 * k + c + 1 < INTERNAL) begin : g_inner
                assign kid[c] = node[4 * k + c + 1];
            end else begin : g_outer
                assign kid[c] = leaf[4 * k + c + 1 - INTERNAL];
            end
        end
        always_ff @(posedge aclk) begin
            node[k] <= kid[0] | kid[1] | kid[2] | kid[3];
        end
    end

    assign root = node[0];

endmodule : rmt_or_tree

`default_nettype wire

// ===== hw/rtl/running_median_tracker.sv =====
// ============================================================================
// running_median_tracker: running median of a stream of signed samples
// Inserts each sample into a sorted chain of cells and reports twice the
// median of everything stored, with the fill count and a drop flag.
// ============================================================================
//
//  Channel   Ports                                   Direction  Meaning
//  --------  --------------------------------------  ---------  ----------------
//  s_        s_valid s_ready s_sample_value          in         one sample
//  m_        m_valid m_ready m_median_doubled        out        median, count,
//            m_sample_count m_dropped                           drop flag
//
//  One transaction is handled at a time. A stored sample is inserted into
//  the chain, gathered by the tree (LEVELS = ceil(log4(CAPACITY)),
//  4 at the default) and summed into the result register; no new sample
//  is taken until the result has been accepted. A dropped sample goes
//  straight to the result state. Reset empties the store at once; m_ready
//  held low stalls the result and keeps s_ready low.
//
`default_nettype none

module running_median_tracker #(
    parameter int CAPACITY = 256
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire logic signed [rmt_pkg::SAMPLE_W-1:0]  s_sample_value,
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic signed [rmt_pkg::MEDIAN_W-1:0]       m_median_doubled,
    output logic        [rmt_pkg::COUNT_OUT_W-1:0]    m_sample_count,
    output logic                                      m_dropped
);

    import rmt_pkg::*;

    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int IDX_W  = $clog2(CAPACITY);
    localparam int LEVELS = ($clog2(CAPACITY) + 1) / 2;
    localparam int WAIT_W = $clog2(LEVELS + 1);

    localparam logic [CNT_W-1:0]  CAP_CNT   = CNT_W'(CAPACITY);
    localparam logic [WAIT_W-1:0] WAIT_DONE = WAIT_W'(LEVELS);

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [MEDIAN_W-1:0]  median_reg, median_next;
    logic                 dropped_reg, dropped_next;
    logic [WAIT_W-1:0]    wait_reg, wait_next;

    logic                 s_fire;
    logic                 full;
    logic                 ins_en;
    logic [CNT_W-1:0]     cnt_m1;
    logic [CNT_W-1:0]     lo_wide;
    logic [CNT_W-1:0]     hi_wide;
    logic [IDX_W-1:0]     lo_idx;
    logic [IDX_W-1:0]     hi_idx;
    link_t                link [CAPACITY+1];
    logic [PICK_W-1:0]    pick [CAPACITY];
    logic [PICK_W-1:0]    root;
    logic [MEDIAN_W-1:0]  mid_sum;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_OUT);
    assign s_fire  = s_valid && s_ready;
    assign full    = (count_reg >= CAP_CNT);
    assign ins_en  = s_fire && !full;

    // Middle positions after the insert: (n-1)/2 and n/2.
    assign cnt_m1  = count_reg - CNT_W'(1);
    assign lo_wide = cnt_m1 >> 1;
    assign hi_wide = count_reg >> 1;
    assign lo_idx  = lo_wide[IDX_W-1:0];
    assign hi_idx  = hi_wide[IDX_W-1:0];

    // Sorted chain; the head acts as an occupied cell below every sample.
    assign link[0] = '{value: '0, gt: 1'b0, occ: 1'b1};

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        rmt_cell #(
            .INDEX (i),
            .IDX_W (IDX_W),
            .CNT_W (CNT_W)
        ) u_cell (
            .aclk     (aclk),
            .ins_en   (ins_en),
            .sample   (s_sample_value),
            .count    (count_reg),
            .lo_idx   (lo_idx),
            .hi_idx   (hi_idx),
            .link_in  (link[i]),
            .link_out (link[i+1]),
            .pick     (pick[i])
        );
    end

    // Gather the two middle values out of the chain.
    rmt_or_tree #(
        .N      (CAPACITY),
        .W      (PICK_W),
        .LEVELS (LEVELS)
    ) u_tree (
        .aclk    (aclk),
        .leaf_in (pick),
        .root    (root)
    );

    // Exact sum of the two middle values, sign-extended to 33 bits.
    assign mid_sum = {root[PICK_W-1], root[PICK_W-1:SAMPLE_W]}
                   + {root[SAMPLE_W-1], root[SAMPLE_W-1:0]};

    // Next state and datapath updates.
    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        median_next  = median_reg;
        dropped_next = dropped_reg;
        wait_next    = wait_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    if (full) begin
                        dropped_next = 1'b1;
                        state_next   = ST_OUT;
                    end else begin
                        dropped_next = 1'b0;
                        count_next   = count_reg + CNT_W'(1);
                        wait_next    = '0;
                        state_next   = ST_GATHER;
                    end
                end
            end
            ST_GATHER: begin
                if (wait_reg == WAIT_DONE) begin
                    median_next = mid_sum;
                    state_next  = ST_OUT;
                end else begin
                    wait_next = wait_reg + WAIT_W'(1);
                end
            end
            ST_OUT: begin
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state is cleared by reset; the median restarts at zero.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            median_reg  <= '0;
            dropped_reg <= 1'b0;
            wait_reg    <= '0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            median_reg  <= median_next;
            dropped_reg <= dropped_next;
            wait_reg    <= wait_next;
        end
    end

    assign m_median_doubled = median_reg;
    assign m_sample_count   = COUNT_OUT_W'(count_reg);
    assign m_dropped        = dropped_reg;

endmodule : running_median_tracker

`default_nettype wire
